FILE: hdl/glpc_pkg.sv
// Shared constants, codes and helpers for the genotype line phase checker.
`default_nettype none

package glpc_pkg;

    localparam int DefMaxFormatFields = 255;

    typedef logic [2:0] t_verdict;
    typedef logic [7:0] t_char;

    // Verdict codes
    localparam t_verdict V_HEADER_PASS = 3'd0;
    localparam t_verdict V_EMPTY_PASS  = 3'd1;
    localparam t_verdict V_PHASED_PASS = 3'd2;
    localparam t_verdict V_BEFORE_HDR  = 3'd3;
    localparam t_verdict V_FEW_COLUMNS = 3'd4;
    localparam t_verdict V_UNPHASED    = 3'd5;
    localparam t_verdict V_NO_GT       = 3'd6;

    // Line kind codes
    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_HASH  = 2'd1;
    localparam logic [1:0] K_DATA  = 2'd2;
    localparam logic [1:0] K_SKIP  = 2'd3;

    // FORMAT token match codes
    localparam logic [1:0] M_START = 2'd0;
    localparam logic [1:0] M_G     = 2'd1;
    localparam logic [1:0] M_GT    = 2'd2;
    localparam logic [1:0] M_NONE  = 2'd3;

    // #CHROM matcher positions
    localparam logic [2:0] CHROM_DONE = 3'd5;
    localparam logic [2:0] CHROM_DEAD = 3'd7;

    // Column handling
    localparam logic [3:0] COL_FORMAT = 4'd8;
    localparam logic [3:0] COL_SAMPLE = 4'd9;
    localparam logic [3:0] COL_SAT    = 4'd10;

    // Characters
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_PIPE  = 8'h7C;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_COLON = 8'h3A;
    localparam t_char CH_HASH  = 8'h23;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_G     = 8'h47;
    localparam t_char CH_T     = 8'h54;

    // Expected letter of "CHROM" after the '#'
    function automatic t_char f_chrom_char(input logic [2:0] pos);
        t_char c;
        case (pos)
            3'd0:    c = 8'h43; // C
            3'd1:    c = 8'h48; // H
            3'd2:    c = 8'h52; // R
            3'd3:    c = 8'h4F; // O
            default: c = 8'h4D; // M
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/genotype_line_phase_checker.sv
// Top level: byte-serial variant-call line parser giving one phase verdict per line.
`default_nettype none

// Channel   | Dir | Handshake                | Payload
// ----------+-----+--------------------------+-------------------------------------
// in        | in  | i_in_valid / o_in_stall  | i_data_byte[7:0], i_end_of_stream
// out       | out | o_out_valid / i_out_stall| o_verdict[2:0]
// cfg       | in  | i_cfg_we (no handshake)  | i_cfg_data (strip_carriage_return)
//
// One byte request per clock sustained while the result register is not
// held full by a stall. A request is captured in the input register, parsed
// in one pass against the running line state, and a verdict (newline or end
// of stream) is written into the result register once that register is free;
// o_out_valid is driven from the result register.
// Reset (synchronous, active low) clears header, line state, the held CR and
// both valid flags; strip_carriage_return returns to 1.
// A stalled output holds its verdict; the input stalls only when a parsed
// byte cannot move on because the result register is full and stalled.

module genotype_line_phase_checker #(
    parameter int MAX_FORMAT_FIELDS = glpc_pkg::DefMaxFormatFields
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input byte stream
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire glpc_pkg::t_char  i_data_byte,
    input  wire                   i_end_of_stream,
    // verdict stream
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output glpc_pkg::t_verdict    o_verdict,
    // configuration
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_data
);
    import glpc_pkg::*;

    // Index width follows the FORMAT token cap; indexes saturate at the cap.
    localparam int IW = $clog2(MAX_FORMAT_FIELDS + 1);
    localparam logic [IW-1:0] MAXV = IW'(MAX_FORMAT_FIELDS);

    typedef struct packed {
        logic          header_seen;
        logic [3:0]    column_count;
        logic [1:0]    line_kind;
        logic [2:0]    chrom_pos;
        logic [IW-1:0] fmt_idx;
        logic [1:0]    fmt_match;
        logic [IW-1:0] gt_idx;
        logic          gt_found;
        logic [IW-1:0] sub_idx;
        logic          gt_reached;
        logic [1:0]    allele_len;
        logic          allele_dot;
        logic          pipe_seen;
        logic          line_failed;
    } t_state;

    // ---------------------------------------------------------------
    // Parser helpers
    // ---------------------------------------------------------------
    function automatic t_state f_clear_sample(input t_state s);
        t_state r;
        r = s;
        r.sub_idx    = '0;
        r.gt_reached = 1'b0;
        r.allele_len = 2'd0;
        r.allele_dot = 1'b0;
        r.pipe_seen  = 1'b0;
        return r;
    endfunction

    // Clears everything but header_seen.
    function automatic t_state f_clear_line(input t_state s);
        t_state r;
        r = f_clear_sample(s);
        r.column_count = 4'd0;
        r.line_kind    = K_START;
        r.chrom_pos    = 3'd0;
        r.fmt_idx      = '0;
        r.fmt_match    = M_START;
        r.gt_idx       = '0;
        r.gt_found     = 1'b0;
        r.line_failed  = 1'b0;
        return r;
    endfunction

    // Empty allele, or one that is just "."
    function automatic logic f_allele_bad(input t_state s);
        return (s.allele_len == 2'd0) || (s.allele_len == 2'd1 && s.allele_dot);
    endfunction

    function automatic t_state f_end_fmt(input t_state s);
        t_state r;
        r = s;
        if (s.fmt_match == M_GT && !s.gt_found && s.fmt_idx < MAXV) begin
            r.gt_found = 1'b1;
            r.gt_idx   = s.fmt_idx;
        end
        if (s.fmt_idx < MAXV) begin
            r.fmt_idx = s.fmt_idx + 1'b1;
        end
        r.fmt_match = M_START;
        return r;
    endfunction

    function automatic t_state f_end_gt(input t_state s);
        t_state r;
        r = s;
        if (f_allele_bad(s) || !s.pipe_seen) begin
            r.line_failed = 1'b1;
        end
        r.gt_reached = 1'b1;
        return r;
    endfunction

    function automatic t_state f_gt_char(input t_state s, input t_char c);
        t_state r;
        r = s;
        if (c == CH_PIPE) begin
            if (f_allele_bad(s)) begin
                r.line_failed = 1'b1;
            end
            r.pipe_seen  = 1'b1;
            r.allele_len = 2'd0;
            r.allele_dot = 1'b0;
        end else if (c == CH_SLASH) begin
            r.line_failed = 1'b1;
        end else begin
            if (s.allele_len == 2'd0) begin
                r.allele_dot = (c == CH_DOT);
            end
            if (s.allele_len < 2'd2) begin
                r.allele_len = s.allele_len + 2'd1;
            end
        end
        return r;
    endfunction

    function automatic t_state f_end_column(input t_state s);
        t_state r;
        r = s;
        if (s.column_count == COL_FORMAT) begin
            r = f_end_fmt(s);
        end else if (s.column_count >= COL_SAMPLE && s.gt_found && !s.line_failed) begin
            if (!s.gt_reached && s.sub_idx == s.gt_idx) begin
                r = f_end_gt(r);
            end
            if (!r.gt_reached) begin
                r.line_failed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_state f_data_char(input t_state s, input t_char c);
        t_state r;
        logic   in_gt;
        r     = s;
        in_gt = !s.gt_reached && (s.sub_idx == s.gt_idx);
        if (c == CH_TAB) begin
            r = f_end_column(s);
            if (s.column_count < COL_SAT) begin
                r.column_count = s.column_count + 4'd1;
            end
            r = f_clear_sample(r);
        end else if (s.column_count == COL_FORMAT) begin
            if (c == CH_COLON) begin
                r = f_end_fmt(s);
            end else if (s.fmt_match == M_START && c == CH_G) begin
                r.fmt_match = M_G;
            end else if (s.fmt_match == M_G && c == CH_T) begin
                r.fmt_match = M_GT;
            end else begin
                r.fmt_match = M_NONE;
            end
        end else if (s.column_count >= COL_SAMPLE && s.gt_found && !s.line_failed) begin
            if (c == CH_COLON) begin
                if (in_gt) begin
                    r = f_end_gt(r);
                end
                if (s.sub_idx < MAXV) begin
                    r.sub_idx = s.sub_idx + 1'b1;
                end
            end else if (in_gt) begin
                r = f_gt_char(s, c);
            end
        end
        return r;
    endfunction

    function automatic t_state f_feed(input t_state s, input t_char c);
        t_state r;
        r = s;
        case (s.line_kind)
            K_START: begin
                if (c == CH_HASH) begin
                    r.line_kind = K_HASH;
                    r.chrom_pos = 3'd0;
                end else if (!s.header_seen) begin
                    r.line_kind = K_SKIP;
                end else begin
                    r.line_kind = K_DATA;
                    r = f_data_char(r, c);
                end
            end
            K_HASH: begin
                if (s.chrom_pos < CHROM_DONE) begin
                    if (c == f_chrom_char(s.chrom_pos)) begin
                        r.chrom_pos = s.chrom_pos + 3'd1;
                        if (s.chrom_pos + 3'd1 == CHROM_DONE) begin
                            r.header_seen = 1'b1;
                        end
                    end else begin
                        r.chrom_pos = CHROM_DEAD;
                    end
                end
            end
            K_DATA: begin
                r = f_data_char(s, c);
            end
            default: begin
                r = s; // skipped line: ignore bytes
            end
        endcase
        return r;
    endfunction

    function automatic t_verdict f_verdict(input t_state s);
        t_state   e;
        t_verdict v;
        e = f_end_column(s);
        case (s.line_kind)
            K_START: v = V_EMPTY_PASS;
            K_HASH:  v = V_HEADER_PASS;
            K_SKIP:  v = V_BEFORE_HDR;
            default: begin
                if (e.column_count < COL_SAMPLE) begin
                    v = V_FEW_COLUMNS;
                end else if (!e.gt_found) begin
                    v = V_NO_GT;
                end else if (e.line_failed) begin
                    v = V_UNPHASED;
                end else begin
                    v = V_PHASED_PASS;
                end
            end
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic     r_strip;         // strip_carriage_return
    logic     r_s1_valid;      // input register holds a byte
    t_char    r_s1_byte;
    logic     r_s1_eos;
    t_state   r_st;            // running line state
    logic     r_pend_cr;       // carriage return held for one byte
    logic     r_out_valid;
    t_verdict r_verdict;

    // ---------------------------------------------------------------
    // Single parse pass
    // ---------------------------------------------------------------
    logic     w_move;          // result register can take a new value
    logic     w_fire;          // input register byte is consumed this cycle
    t_state   w_s_cr;          // after replaying a held CR
    t_state   w_s_byte;        // after the byte itself
    t_state   n_st;
    logic     n_pend_cr;
    logic     w_res;
    t_verdict w_verdict;

    assign w_move     = !r_out_valid || !i_out_stall;
    assign w_fire     = r_s1_valid && w_move;
    assign o_in_stall = r_s1_valid && !w_move;

    always_comb begin
        // A held CR not followed by LF is an ordinary character.
        if (r_pend_cr && r_s1_byte != CH_LF) begin
            w_s_cr = f_feed(r_st, CH_CR);
        end else begin
            w_s_cr = r_st;
        end

        w_res     = 1'b0;
        w_verdict = V_EMPTY_PASS;
        n_pend_cr = 1'b0;

        if (r_s1_byte == CH_LF) begin
            w_res     = 1'b1;
            w_verdict = f_verdict(w_s_cr);
            w_s_byte  = f_clear_line(w_s_cr);
        end else if (r_s1_byte == CH_CR && r_strip) begin
            w_s_byte  = w_s_cr;
            n_pend_cr = 1'b1;
        end else begin
            w_s_byte  = f_feed(w_s_cr, r_s1_byte);
        end

        n_st = w_s_byte;
        // Stream end closes an open line and starts a fresh stream.
        if (r_s1_eos) begin
            n_pend_cr = 1'b0;
            if (r_s1_byte != CH_LF) begin
                w_res     = 1'b1;
                w_verdict = f_verdict(w_s_byte);
            end
            n_st             = f_clear_line(w_s_byte);
            n_st.header_seen = 1'b0;
        end
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= 1'b1;
        end else if (i_cfg_we) begin
            r_strip <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_byte <= i_data_byte;
            r_s1_eos  <= i_end_of_stream;
        end
    end

    // Line state; clearing from all-zero leaves header_seen low too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= f_clear_line('0);
            r_pend_cr <= 1'b0;
        end else if (w_fire) begin
            r_st      <= n_st;
            r_pend_cr <= n_pend_cr;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= w_fire && w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res) begin
            r_verdict <= w_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

`default_nettype wire

FILE: hdl/glpc_checker.sv
// Port-level assertion checker for the genotype line phase checker, with its bind.
`default_nettype none

module glpc_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire glpc_pkg::t_char i_data_byte,
    input wire                  i_end_of_stream,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire glpc_pkg::t_verdict o_verdict,
    input wire                  i_cfg_we,
    input wire                  i_cfg_data
);
    import glpc_pkg::*;

    // Stalled result keeps valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict dropped while stalled");

    // Stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_verdict))
        else $error("verdict changed while stalled");

    // Only defined verdict codes
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= V_NO_GT))
        else $error("undefined verdict code");

    // A newline always yields a verdict once the result register is free
    a_lf_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_data_byte == CH_LF)
        ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("newline without verdict");

    // Nothing shows out of reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind genotype_line_phase_checker glpc_checker u_glpc_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_genotype_line_phase_checker.sv
// Self-checking testbench for the genotype line phase checker: directed lines, then random streams.
`default_nettype none

module tb_genotype_line_phase_checker;
    import glpc_pkg::*;

    localparam int          MAX_FMT    = glpc_pkg::DefMaxFormatFields;
    localparam logic [39:0] CHROM_WORD = "CHROM";

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic     clk;
    logic     rst_n;
    logic     in_valid;
    t_char    in_byte;
    logic     in_eos;
    logic     out_stall;
    logic     cfg_we;
    logic     cfg_data;
    logic     o_in_stall;
    logic     o_out_valid;
    t_verdict o_verdict;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    genotype_line_phase_checker u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (in_byte),
        .i_end_of_stream (in_eos),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_verdict       (o_verdict),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_verdict exp_verdicts[$];   // verdicts predicted but not yet seen
    t_char    txt_q[$];          // text built up by the line builders
    int       n_err      = 0;
    int       n_sent     = 0;    // byte requests accepted
    int       n_verdicts = 0;    // verdicts predicted
    int       hold_left  = 0;    // forced receiver hold, in cycles
    bit       tx_idle_en = 1'b1; // sender inserts random gaps
    bit       rx_idle_en = 1'b1; // receiver stalls at random

    string word_chars   = "ACGTN0123456789.;=,";
    string fmt_names[8] = '{"DP", "GQ", "AD", "G", "GTX", "T", "PS", "GT"};

    // ------------------------------------------------------------------
    // Line-state predictor. Mirrors the parser one byte at a time; the
    // running state below is the checker's own copy, it never peeks into
    // the DUT.
    // ------------------------------------------------------------------
    logic       strip_cr;     // config: drop CR in front of LF
    logic       hdr_seen;     // "#CHROM" seen in this stream
    logic [3:0] col_cnt;      // tabs in the line, sat at COL_SAT
    logic [1:0] kind;         // K_START / K_HASH / K_DATA / K_SKIP
    logic [2:0] chrom_pos;    // progress through "CHROM" after '#'
    logic [7:0] fmt_idx;      // current FORMAT token
    logic [1:0] fmt_match;    // "GT" matcher on the current token
    logic [7:0] gt_idx;       // FORMAT index of the first GT
    logic       gt_found;
    logic [7:0] sub_idx;      // subfield index inside a sample
    logic       gt_reached;   // GT subfield of this sample closed
    logic [1:0] allele_len;   // sat at 2
    logic       allele_dot;   // allele started with '.'
    logic       pipe_seen;
    logic       line_failed;
    logic       cr_held;      // CR waiting to see if LF follows

    function automatic void clr_sample();
        sub_idx    = '0;
        gt_reached = 1'b0;
        allele_len = '0;
        allele_dot = 1'b0;
        pipe_seen  = 1'b0;
    endfunction

    function automatic void clr_line();
        col_cnt     = '0;
        kind        = K_START;
        chrom_pos   = '0;
        fmt_idx     = '0;
        fmt_match   = M_START;
        gt_idx      = '0;
        gt_found    = 1'b0;
        line_failed = 1'b0;
        clr_sample();
    endfunction

    // empty allele, or a lone '.'
    function automatic logic allele_bad();
        return (allele_len == 2'd0) || (allele_len == 2'd1 && allele_dot);
    endfunction

    function automatic void close_fmt_token();
        // first GT wins; tokens past the limit are not searched
        if (fmt_match == M_GT && !gt_found && fmt_idx < MAX_FMT) begin
            gt_found = 1'b1;
            gt_idx   = fmt_idx;
        end
        if (fmt_idx < MAX_FMT)
            fmt_idx++;
        fmt_match = M_START;
    endfunction

    function automatic void close_gt();
        if (allele_bad() || !pipe_seen)
            line_failed = 1'b1;
        gt_reached = 1'b1;
    endfunction

    function automatic void close_column();
        if (col_cnt == COL_FORMAT) begin
            close_fmt_token();
        end else if (col_cnt >= COL_SAMPLE && gt_found && !line_failed) begin
            if (!gt_reached && sub_idx == gt_idx)
                close_gt();
            // sample ended before its GT subfield
            if (!gt_reached)
                line_failed = 1'b1;
        end
    endfunction

    function automatic void parse_data_char(input t_char c);
        logic in_gt;
        if (c == CH_TAB) begin
            close_column();
            if (col_cnt < COL_SAT)
                col_cnt++;
            clr_sample();
        end else if (col_cnt == COL_FORMAT) begin
            if (c == CH_COLON)
                close_fmt_token();
            else if (fmt_match == M_START && c == CH_G)
                fmt_match = M_G;
            else if (fmt_match == M_G && c == CH_T)
                fmt_match = M_GT;
            else
                fmt_match = M_NONE;
        end else if (col_cnt >= COL_SAMPLE && gt_found && !line_failed) begin
            in_gt = !gt_reached && sub_idx == gt_idx;
            if (c == CH_COLON) begin
                if (in_gt)
                    close_gt();
                if (sub_idx < MAX_FMT)
                    sub_idx++;
            end else if (in_gt) begin
                if (c == CH_PIPE) begin
                    if (allele_bad())
                        line_failed = 1'b1;
                    pipe_seen  = 1'b1;
                    allele_len = '0;
                    allele_dot = 1'b0;
                end else if (c == CH_SLASH) begin
                    line_failed = 1'b1;
                end else begin
                    if (allele_len == 2'd0)
                        allele_dot = (c == CH_DOT);
                    if (allele_len < 2'd2)
                        allele_len++;
                end
            end
        end
    endfunction

    function automatic void parse_char(input t_char c);
        if (kind == K_START) begin
            if (c == CH_HASH) begin
                kind      = K_HASH;
                chrom_pos = '0;
            end else if (!hdr_seen) begin
                kind = K_SKIP;
            end else begin
                kind = K_DATA;
                parse_data_char(c);
            end
        end else if (kind == K_HASH) begin
            if (chrom_pos < CHROM_DONE) begin
                if (c == CHROM_WORD[39 - 8 * int'(chrom_pos) -: 8]) begin
                    chrom_pos++;
                    if (chrom_pos == CHROM_DONE)
                        hdr_seen = 1'b1;
                end else begin
                    chrom_pos = CHROM_DEAD;
                end
            end
        end else if (kind == K_DATA) begin
            parse_data_char(c);
        end
    endfunction

    function automatic t_verdict close_line();
        t_verdict v;
        if (kind == K_START) begin
            v = V_EMPTY_PASS;
        end else if (kind == K_HASH) begin
            v = V_HEADER_PASS;
        end else if (kind == K_SKIP) begin
            v = V_BEFORE_HDR;
        end else begin
            close_column();
            if (col_cnt < COL_SAMPLE)
                v = V_FEW_COLUMNS;
            else if (!gt_found)
                v = V_NO_GT;
            else if (line_failed)
                v = V_UNPHASED;
            else
                v = V_PHASED_PASS;
        end
        clr_line();
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers one byte request, waits for the handshake, then runs
    // the predictor on it. Valid is only dropped when a gap is inserted,
    // so back-to-back requests never see a low/high pair in one step.
    // ------------------------------------------------------------------
    task automatic send_byte(input t_char c, input logic e);
        int   gap;
        int   r;
        logic acc;
        gap = 0;
        if (tx_idle_en) begin
            r   = $urandom_range(0, 99);
            gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_eos   <= e;
        // stall is stable at the falling edge; it decides the next rising edge
        do begin
            @(negedge clk);
            acc = (o_in_stall === 1'b0);
            @(posedge clk);
        end while (!acc);
        n_sent++;

        // a held CR turns into an ordinary character unless LF follows
        if (cr_held) begin
            cr_held = 1'b0;
            if (c != CH_LF)
                parse_char(CH_CR);
        end
        if (c == CH_LF) begin
            exp_verdicts.push_back(close_line());
            n_verdicts++;
        end else if (c == CH_CR && strip_cr) begin
            cr_held = 1'b1;
        end else begin
            parse_char(c);
        end
        // end of stream closes an open line and forgets the header
        if (e) begin
            cr_held = 1'b0;
            if (c != CH_LF) begin
                exp_verdicts.push_back(close_line());
                n_verdicts++;
            end
            hdr_seen = 1'b0;
            clr_line();
        end
    endtask

    task automatic send_txt(input logic eos_last);
        t_char c;
        while (txt_q.size() > 0) begin
            c = txt_q.pop_front();
            send_byte(c, eos_last && (txt_q.size() == 0));
        end
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            txt_q.push_back(t_char'(s[i]));
    endtask

    task automatic add_word(input int len);
        for (int i = 0; i < len; i++)
            txt_q.push_back(t_char'(word_chars[$urandom_range(0, word_chars.len() - 1)]));
    endtask

    // eight plain columns ahead of FORMAT
    task automatic add_fixed_cols();
        add_str("1\t100\t.\tA\tG\t50\tPASS\t.\t");
    endtask

    // random GT subfield: mostly phased, some '/', some bad alleles
    task automatic add_gt();
        int n;
        int r;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                txt_q.push_back(($urandom_range(0, 99) < 88) ? CH_PIPE : CH_SLASH);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                txt_q.push_back(t_char'(8'h30 + $urandom_range(0, 9)));
                if ($urandom_range(0, 4) == 0)
                    txt_q.push_back(t_char'(8'h30 + $urandom_range(0, 9)));
            end else if (r < 82) begin
                txt_q.push_back(CH_DOT);
            end else if (r < 90) begin
                // empty allele
            end else if (r < 95) begin
                add_str("..");
            end else begin
                add_str(".5");
            end
        end
    endtask

    // well-formed data line with random content and the odd defect
    task automatic add_data_line();
        int ncols;
        int ntok;
        int gpos;
        int nsub;
        int r;
        ncols = ($urandom_range(0, 99) < 88) ? $urandom_range(10, 13) : $urandom_range(1, 9);
        ntok  = $urandom_range(1, 4);
        gpos  = ($urandom_range(0, 99) < 88) ? $urandom_range(0, ntok - 1) : -1;
        for (int col = 0; col < ncols; col++) begin
            if (col > 0)
                txt_q.push_back(CH_TAB);
            if (col < 8) begin
                add_word($urandom_range(0, 4));
            end else if (col == 8) begin
                for (int i = 0; i < ntok; i++) begin
                    if (i > 0)
                        txt_q.push_back(CH_COLON);
                    if (i == gpos)
                        add_str("GT");
                    else
                        add_str(fmt_names[$urandom_range(0, 7)]);
                end
            end else begin
                r    = $urandom_range(0, 99);
                nsub = (r < 4) ? 0 : (r < 10) ? $urandom_range(0, ntok - 1) : ntok;
                for (int j = 0; j < nsub; j++) begin
                    if (j > 0)
                        txt_q.push_back(CH_COLON);
                    if (j == gpos)
                        add_gt();
                    else
                        add_word($urandom_range(0, 3));
                end
            end
        end
        if ($urandom_range(0, 99) < 4)
            txt_q.push_back(CH_TAB);
        if ($urandom_range(0, 99) < 15)
            txt_q.push_back(CH_CR);
        txt_q.push_back(CH_LF);
    endtask

    // Drop valid and let every predicted verdict come back, then wait out
    // bytes still in flight that make no verdict.
    task automatic wait_verdicts_drained();
        in_valid <= 1'b0;
        while (exp_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_cr_strip(input logic v);
        wait_verdicts_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        strip_cr = v;
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall pattern, or a forced hold counted down here
    // ------------------------------------------------------------------
    initial begin
        int run_len;
        int r;
        out_stall = 1'b0;
        run_len   = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (run_len > 0) begin
                run_len--;
            end else if (!rx_idle_en) begin
                out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_stall <= 1'b0;
                    run_len = $urandom_range(0, 12);
                end else if (r < 92) begin
                    out_stall <= 1'b1;
                    run_len = $urandom_range(0, 3);
                end else begin
                    out_stall <= 1'b1;
                    run_len = $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict checker: valid and stall are sampled at the falling edge, so
    // a verdict seen here is the one taken at the next rising edge.
    // ------------------------------------------------------------------
    initial begin
        t_verdict want;
        forever begin
            @(negedge clk);
            if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
                if (exp_verdicts.size() == 0) begin
                    n_err++;
                    if (n_err <= 50)
                        $display("%0t: unexpected verdict, expected none, actual %0d",
                                 $time, o_verdict);
                end else begin
                    want = exp_verdicts.pop_front();
                    if (o_verdict !== want) begin
                        n_err++;
                        if (n_err <= 50)
                            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                     $time, want, o_verdict);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // comment lines, empty lines and data ahead of the header
    task automatic test_header_lines();
        add_str("AB\tC\n");        // before header
        add_str("\n");             // empty line
        add_str("#CHRX\n");        // comment, header still not seen
        add_str("#CHR\n");         // cut short
        add_str("1\t2\n");         // still before header
        add_str("#CHROM\tPOS\n");  // header
        send_txt(1'b0);
    endtask

    // every verdict on a data line, and the GT corner cases
    task automatic test_data_verdicts();
        add_str("1\t2\t3\n");                               // too few columns
        add_fixed_cols(); add_str("DP:GQ\t1:2\n");           // no GT
        add_fixed_cols(); add_str("GT\t0|1\t1|1\n");         // phased
        add_fixed_cols(); add_str("DP:GT\t5:0|1|2\n");       // GT not first
        add_fixed_cols(); add_str("GT\t0/1\n");              // unphased
        add_fixed_cols(); add_str("GT\t.|1\n");              // missing allele
        add_fixed_cols(); add_str("GT\t|1\n");               // empty allele
        add_fixed_cols(); add_str("GT\t0\n");                // no separator
        add_fixed_cols(); add_str("GT:GT\t0|1:0/1\n");       // repeated GT, first counts
        add_fixed_cols(); add_str("DP:GT\t5\n");             // GT subfield missing
        add_fixed_cols(); add_str("GT\t0|1\t\n");            // trailing tab, empty sample
        add_fixed_cols(); add_str("GT\t..|1\n");             // two-char dotted allele is fine
        add_fixed_cols(); add_str("GT\n");                   // FORMAT but no sample
        add_fixed_cols(); add_str("GT\t\n");                 // one empty sample
        send_txt(1'b0);
    endtask

    // byte values at both ends of the range
    task automatic test_byte_extremes();
        add_fixed_cols(); add_str("GT\t");
        txt_q.push_back(8'h00); txt_q.push_back(CH_PIPE); txt_q.push_back(8'hFF);
        txt_q.push_back(CH_LF);
        txt_q.push_back(8'hFF); txt_q.push_back(CH_LF);
        txt_q.push_back(8'h00); txt_q.push_back(CH_LF);
        send_txt(1'b0);
    endtask

    // GT at the last searched FORMAT index, then one past it
    task automatic test_many_tokens();
        add_fixed_cols();
        for (int i = 0; i < MAX_FMT - 1; i++) add_str("X:");
        add_str("GT\t");
        for (int i = 0; i < MAX_FMT - 1; i++) txt_q.push_back(CH_COLON);
        add_str("0|1\n");
        add_fixed_cols();
        for (int i = 0; i < MAX_FMT; i++) add_str("X:");
        add_str("GT\t0|1\n");
        send_txt(1'b0);
    endtask

    // CR handling with stripping on (reset value), then off, then on again
    task automatic test_carriage_return();
        txt_q.push_back(CH_CR); txt_q.push_back(CH_LF);             // dropped CR
        add_fixed_cols(); add_str("GT\t0|1");
        txt_q.push_back(CH_CR); txt_q.push_back(CH_LF);
        add_fixed_cols(); add_str("GT\t0|");                        // CR inside an allele
        txt_q.push_back(CH_CR); add_str("1\n");
        send_txt(1'b0);
        txt_q.push_back(CH_CR);                                     // held CR at stream end
        send_txt(1'b1);

        set_cr_strip(1'b0);
        add_str("#CHROM\n");
        add_fixed_cols(); add_str("GT\t0|1");
        txt_q.push_back(CH_CR); txt_q.push_back(CH_LF);
        txt_q.push_back(CH_CR); txt_q.push_back(CH_LF);             // CR is a data char
        send_txt(1'b0);
        set_cr_strip(1'b1);
    endtask

    // end of stream on an open line, on a newline, and header reset after it
    task automatic test_end_of_stream();
        add_str("#CHROM\n");
        add_fixed_cols(); add_str("GT\t0|1");
        send_txt(1'b1);
        add_fixed_cols(); add_str("GT\t0|1\n");    // header forgotten
        add_str("#CHROM\n\n");
        send_txt(1'b1);
        add_str("x\n#CHROM\n");
        send_txt(1'b0);
    endtask

    // long receiver hold while the sender keeps pushing short lines
    task automatic test_backpressure();
        wait_verdicts_drained();
        tx_idle_en = 1'b0;
        @(negedge clk);
        hold_left = 300;
        @(posedge clk);
        for (int i = 0; i < 40; i++)
            add_str((i % 2) ? "\n" : "#\n");
        send_txt(1'b0);
        wait_verdicts_drained();
        tx_idle_en = 1'b1;
    endtask

    // random streams, with the CR setting and idling changed per phase
    task automatic test_random();
        int b0;
        int v0;
        int nlines;
        int r;
        b0 = n_sent;
        v0 = n_verdicts;
        for (int ph = 0; (n_sent - b0 < 1500) || (n_verdicts - v0 < 48); ph++) begin
            set_cr_strip((ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            tx_idle_en = (ph % 4 != 2);
            rx_idle_en = (ph % 4 != 3);
            if ($urandom_range(0, 9) != 0)
                add_str("##fileformat=VCFv4.2\n#CHROM\tPOS\n");
            nlines = $urandom_range(6, 14);
            for (int n = 0; n < nlines; n++) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    add_data_line();
                end else if (r < 85) begin
                    // noise: any byte value, stray newlines included
                    repeat ($urandom_range(0, 15))
                        txt_q.push_back(t_char'($urandom_range(0, 255)));
                    txt_q.push_back(CH_LF);
                end else if (r < 93) begin
                    txt_q.push_back(CH_HASH);
                    add_word($urandom_range(0, 6));
                    txt_q.push_back(CH_LF);
                end else if (r < 97) begin
                    txt_q.push_back(CH_LF);
                end else begin
                    txt_q.push_back(CH_CR);
                    add_word($urandom_range(1, 3));
                    txt_q.push_back(CH_CR);
                    txt_q.push_back(CH_LF);
                end
                send_txt(1'b0);
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                add_data_line();
                send_txt(1'b1);
            end else if (r < 70) begin
                add_word($urandom_range(1, 3));
                send_txt(1'b1);
            end
        end
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = '0;
        in_eos   = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        strip_cr = 1'b1;
        hdr_seen = 1'b0;
        cr_held  = 1'b0;
        clr_line();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_lines();
        test_data_verdicts();
        test_byte_extremes();
        test_many_tokens();
        test_carriage_return();
        test_end_of_stream();
        test_backpressure();
        test_random();

        wait_verdicts_drained();
        repeat (10) @(posedge clk);
        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/glpc_pkg.sv
hdl/genotype_line_phase_checker.sv
hdl/glpc_checker.sv
tb/sv/tb_genotype_line_phase_checker.sv
